/* design/kcms_pkg.sv */
// Shared types, constants and pattern tables of the key code to Morse sequencer.
`default_nettype none

package kcms_pkg;

  localparam int MAX_SYMBOLS_DEF = 7;
  localparam int QUEUE_DEPTH     = 2;

  localparam int PAT_W       = 8;
  localparam int PAT_LEN_W   = 3;
  localparam int LEN_W       = 4;
  localparam int KIND_W      = 2;
  localparam int CODE_W      = 8;
  localparam int GROUP_W     = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 4;

  localparam logic [KIND_W-1:0] KIND_DOT      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DASH     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ELEM_GAP = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CHAR_GAP = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] REG_DOT  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DASH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_EGAP = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CGAP = 2'd3;

  localparam logic [LEN_W-1:0] RST_DOT  = 4'd1;
  localparam logic [LEN_W-1:0] RST_DASH = 4'd4;
  localparam logic [LEN_W-1:0] RST_EGAP = 4'd1;
  localparam logic [LEN_W-1:0] RST_CGAP = 4'd4;

  typedef struct packed {
    logic [CODE_W-1:0]  key_code;
    logic [GROUP_W-1:0] layout_group;
  } key_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] element_kind;
    logic              tone_on;
    logic [LEN_W-1:0]  length_units;
    logic              last;
  } elem_item_t;

  typedef struct packed {
    logic [LEN_W-1:0] dot;
    logic [LEN_W-1:0] dash;
    logic [LEN_W-1:0] egap;
    logic [LEN_W-1:0] cgap;
  } cfg_len_t;

  // marks: first symbol in the top bit, 1 is a dash
  typedef struct packed {
    logic [PAT_LEN_W-1:0] len;
    logic [PAT_W-1:0]     marks;
  } pat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TONE,
    ST_GAP,
    ST_CHAR
  } back_state_t;

  function automatic logic [LEN_W-1:0] len_of(input logic [LEN_W-1:0] v);
    return (v == '0) ? LEN_W'(1) : v;
  endfunction

  function automatic pat_t latin_pat(input logic [5:0] idx);
    pat_t p;
    p = '0;
    case (idx)
      6'd10: p = '{3'd5, 8'b01111000};
      6'd11: p = '{3'd5, 8'b00111000};
      6'd12: p = '{3'd5, 8'b00011000};
      6'd13: p = '{3'd5, 8'b00001000};
      6'd14: p = '{3'd5, 8'b00000000};
      6'd15: p = '{3'd5, 8'b10000000};
      6'd16: p = '{3'd5, 8'b11000000};
      6'd17: p = '{3'd5, 8'b11100000};
      6'd18: p = '{3'd5, 8'b11110000};
      6'd19: p = '{3'd5, 8'b11111000};
      6'd24: p = '{3'd4, 8'b11010000};
      6'd25: p = '{3'd3, 8'b01100000};
      6'd26: p = '{3'd1, 8'b00000000};
      6'd27: p = '{3'd3, 8'b01000000};
      6'd28: p = '{3'd1, 8'b10000000};
      6'd29: p = '{3'd4, 8'b10110000};
      6'd30: p = '{3'd3, 8'b00100000};
      6'd31: p = '{3'd2, 8'b00000000};
      6'd32: p = '{3'd3, 8'b11100000};
      6'd33: p = '{3'd4, 8'b01100000};
      6'd38: p = '{3'd2, 8'b01000000};
      6'd39: p = '{3'd3, 8'b00000000};
      6'd40: p = '{3'd3, 8'b10000000};
      6'd41: p = '{3'd4, 8'b00100000};
      6'd42: p = '{3'd3, 8'b11000000};
      6'd43: p = '{3'd4, 8'b00000000};
      6'd44: p = '{3'd4, 8'b01110000};
      6'd45: p = '{3'd3, 8'b10100000};
      6'd46: p = '{3'd4, 8'b01000000};
      6'd52: p = '{3'd4, 8'b11000000};
      6'd53: p = '{3'd4, 8'b10010000};
      6'd54: p = '{3'd4, 8'b10100000};
      6'd55: p = '{3'd4, 8'b00010000};
      6'd56: p = '{3'd4, 8'b10000000};
      6'd57: p = '{3'd2, 8'b10000000};
      6'd58: p = '{3'd2, 8'b11000000};
      6'd59: p = '{3'd6, 8'b01010100};
      6'd60: p = '{3'd6, 8'b00000000};
      6'd61: p = '{3'd5, 8'b10010000};
      default: p = '0;
    endcase
    return p;
  endfunction

  function automatic pat_t cyr_pat(input logic [5:0] idx);
    pat_t p;
    p = '0;
    case (idx)
      6'd24: p = '{3'd4, 8'b01110000};
      6'd25: p = '{3'd4, 8'b10100000};
      6'd26: p = '{3'd3, 8'b00100000};
      6'd27: p = '{3'd3, 8'b10100000};
      6'd28: p = '{3'd1, 8'b00000000};
      6'd29: p = '{3'd2, 8'b10000000};
      6'd30: p = '{3'd3, 8'b11000000};
      6'd31: p = '{3'd4, 8'b11110000};
      6'd32: p = '{3'd4, 8'b11010000};
      6'd33: p = '{3'd4, 8'b11000000};
      6'd34: p = '{3'd4, 8'b00000000};
      6'd35: p = '{3'd6, 8'b01101000};
      6'd38: p = '{3'd4, 8'b00100000};
      6'd39: p = '{3'd4, 8'b10110000};
      6'd40: p = '{3'd3, 8'b01100000};
      6'd41: p = '{3'd2, 8'b01000000};
      6'd42: p = '{3'd4, 8'b01100000};
      6'd43: p = '{3'd3, 8'b01000000};
      6'd44: p = '{3'd3, 8'b11100000};
      6'd45: p = '{3'd4, 8'b01000000};
      6'd46: p = '{3'd3, 8'b10000000};
      6'd47: p = '{3'd4, 8'b00010000};
      6'd48: p = '{3'd7, 8'b00010000};
      6'd52: p = '{3'd4, 8'b01010000};
      6'd53: p = '{3'd4, 8'b11100000};
      6'd54: p = '{3'd3, 8'b00000000};
      6'd55: p = '{3'd2, 8'b11000000};
      6'd56: p = '{3'd2, 8'b00000000};
      6'd57: p = '{3'd1, 8'b10000000};
      6'd58: p = '{3'd4, 8'b10010000};
      6'd59: p = '{3'd4, 8'b10000000};
      6'd60: p = '{3'd3, 8'b00100000};
      6'd61: p = '{3'd6, 8'b00000000};
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

/* design/kcms_front.sv */
// Front end: takes key items, looks up the Morse pattern and pushes it to the queue.
`default_nettype none

module kcms_front #(
  parameter int MAX_SYMBOLS = kcms_pkg::MAX_SYMBOLS_DEF,
  localparam int CNT_W      = $clog2(MAX_SYMBOLS + 1),
  localparam int ENTRY_W    = CNT_W + kcms_pkg::PAT_W
) (
  input  wire logic                 key_valid,
  output logic                      key_ready,
  input  wire kcms_pkg::key_item_t  key_item,
  input  wire logic                 q_full,
  output logic                      push,
  output logic [ENTRY_W-1:0]        push_data
);

  kcms_pkg::pat_t   pat;
  logic [CNT_W-1:0] cnt;

  always_comb begin
    pat = '0;
    // codes of 64 and above have no table entry
    if (key_item.key_code[7:6] == 2'b00) begin
      if (key_item.layout_group != '0) begin
        pat = kcms_pkg::cyr_pat(key_item.key_code[5:0]);
      end else begin
        pat = kcms_pkg::latin_pat(key_item.key_code[5:0]);
      end
    end
  end

  // cut long patterns to the symbol limit
  always_comb begin
    if (int'(pat.len) > MAX_SYMBOLS) begin
      cnt = CNT_W'(MAX_SYMBOLS);
    end else begin
      cnt = CNT_W'(pat.len);
    end
  end

  assign key_ready = !q_full;
  assign push      = key_valid && !q_full;
  assign push_data = {cnt, pat.marks};

endmodule

`default_nettype wire

/* design/kcms_queue.sv */
// Short register queue between the front end and the element sequencer.
`default_nettype none

module kcms_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = kcms_pkg::QUEUE_DEPTH,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (int'(p) == DEPTH - 1) ? '0 : p + PTR_W'(1);
  endfunction

  assign full      = (int'(count) == DEPTH);
  assign not_empty = (count != '0);
  assign rdata     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

/* design/kcms_back.sv */
// Back end: steps through one pattern and drives the registered element output.
`default_nettype none

module kcms_back #(
  parameter int MAX_SYMBOLS = kcms_pkg::MAX_SYMBOLS_DEF,
  localparam int CNT_W      = $clog2(MAX_SYMBOLS + 1),
  localparam int ENTRY_W    = CNT_W + kcms_pkg::PAT_W
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire kcms_pkg::cfg_len_t  cfg_len,
  input  wire logic                q_valid,
  input  wire logic [ENTRY_W-1:0]  q_data,
  output logic                     pop,
  output logic                     elem_valid,
  input  wire logic                elem_ready,
  output kcms_pkg::elem_item_t     elem_item
);

  kcms_pkg::back_state_t       state;
  kcms_pkg::back_state_t       state_next;
  logic [kcms_pkg::PAT_W-1:0]  marks;
  logic [kcms_pkg::PAT_W-1:0]  marks_next;
  logic [CNT_W-1:0]            rem;
  logic [CNT_W-1:0]            rem_next;
  kcms_pkg::elem_item_t        elem_item_next;
  logic                        emit;
  logic                        out_free;
  logic [CNT_W-1:0]            q_cnt;
  logic [kcms_pkg::PAT_W-1:0]  q_marks;
  kcms_pkg::elem_item_t        gap_item;
  kcms_pkg::elem_item_t        char_item;

  function automatic kcms_pkg::elem_item_t tone_item(input logic dash,
                                                     input kcms_pkg::cfg_len_t c);
    kcms_pkg::elem_item_t t;
    t.element_kind = dash ? kcms_pkg::KIND_DASH : kcms_pkg::KIND_DOT;
    t.tone_on      = 1'b1;
    t.length_units = dash ? c.dash : c.dot;
    t.last         = 1'b0;
    return t;
  endfunction

  assign q_cnt    = q_data[ENTRY_W-1:kcms_pkg::PAT_W];
  assign q_marks  = q_data[kcms_pkg::PAT_W-1:0];
  assign out_free = !elem_valid || elem_ready;

  assign gap_item  = '{kcms_pkg::KIND_ELEM_GAP, 1'b0, cfg_len.egap, 1'b0};
  assign char_item = '{kcms_pkg::KIND_CHAR_GAP, 1'b0, cfg_len.cgap, 1'b1};

  always_comb begin
    state_next = state;
    case (state)
      kcms_pkg::ST_IDLE: begin
        if (q_valid && out_free && q_cnt != '0) begin
          state_next = kcms_pkg::ST_GAP;
        end
      end
      kcms_pkg::ST_TONE: begin
        if (out_free) begin
          state_next = kcms_pkg::ST_GAP;
        end
      end
      kcms_pkg::ST_GAP: begin
        if (out_free) begin
          state_next = (rem == '0) ? kcms_pkg::ST_CHAR : kcms_pkg::ST_TONE;
        end
      end
      kcms_pkg::ST_CHAR: begin
        if (out_free) begin
          state_next = kcms_pkg::ST_IDLE;
        end
      end
      default: state_next = kcms_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop            = 1'b0;
    emit           = 1'b0;
    elem_item_next = elem_item;
    marks_next     = marks;
    rem_next       = rem;
    case (state)
      kcms_pkg::ST_IDLE: begin
        if (q_valid && out_free) begin
          pop  = 1'b1;
          emit = 1'b1;
          // an empty pattern closes at once with the character gap
          if (q_cnt == '0) begin
            elem_item_next = char_item;
          end else begin
            elem_item_next = tone_item(q_marks[kcms_pkg::PAT_W-1], cfg_len);
            marks_next     = q_marks << 1;
            rem_next       = q_cnt - CNT_W'(1);
          end
        end
      end
      kcms_pkg::ST_TONE: begin
        if (out_free) begin
          emit           = 1'b1;
          elem_item_next = tone_item(marks[kcms_pkg::PAT_W-1], cfg_len);
          marks_next     = marks << 1;
          rem_next       = rem - CNT_W'(1);
        end
      end
      kcms_pkg::ST_GAP: begin
        if (out_free) begin
          emit           = 1'b1;
          elem_item_next = gap_item;
        end
      end
      kcms_pkg::ST_CHAR: begin
        if (out_free) begin
          emit           = 1'b1;
          elem_item_next = char_item;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= kcms_pkg::ST_IDLE;
      elem_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        elem_valid <= 1'b1;
      end else if (elem_ready) begin
        elem_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    marks <= marks_next;
    rem   <= rem_next;
    if (emit) begin
      elem_item <= elem_item_next;
    end
  end

endmodule

`default_nettype wire

/* design/keycode_to_morse_sequencer.sv */
// Top level of the key code to Morse element sequencer.
`default_nettype none

// A key item with a pattern of n dots and dashes (n at most MAX_SYMBOLS) yields
// 2n+1 element items: tone, element gap, ..., character gap with last set. The
// element sequencer sends one item per cycle while elem_ready is high and starts
// the next key right after the character gap; an unmapped key yields only the
// character gap. Key items are looked up on entry and wait in a two-entry
// queue, so keys are taken while an earlier one is still being sent. Lengths
// come from the four 4-bit registers written through cfg_we/cfg_index/cfg_data;
// a register holding 0 reads as 1.

module keycode_to_morse_sequencer #(
  parameter int MAX_SYMBOLS = kcms_pkg::MAX_SYMBOLS_DEF,
  parameter int QUEUE_DEPTH = kcms_pkg::QUEUE_DEPTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                key_valid,
  output logic                                     key_ready,
  input  wire kcms_pkg::key_item_t                 key_item,
  output logic                                     elem_valid,
  input  wire logic                                elem_ready,
  output kcms_pkg::elem_item_t                     elem_item,
  input  wire logic                                cfg_we,
  input  wire logic [kcms_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [kcms_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CNT_W   = $clog2(MAX_SYMBOLS + 1);
  localparam int ENTRY_W = CNT_W + kcms_pkg::PAT_W;

  logic [kcms_pkg::LEN_W-1:0] dot_units;
  logic [kcms_pkg::LEN_W-1:0] dash_units;
  logic [kcms_pkg::LEN_W-1:0] element_gap_units;
  logic [kcms_pkg::LEN_W-1:0] char_gap_units;
  kcms_pkg::cfg_len_t         cfg_len;

  logic               push;
  logic [ENTRY_W-1:0] push_data;
  logic               q_full;
  logic               q_valid;
  logic [ENTRY_W-1:0] q_data;
  logic               pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_units         <= kcms_pkg::RST_DOT;
      dash_units        <= kcms_pkg::RST_DASH;
      element_gap_units <= kcms_pkg::RST_EGAP;
      char_gap_units    <= kcms_pkg::RST_CGAP;
    end else if (cfg_we) begin
      case (cfg_index)
        kcms_pkg::REG_DOT:  dot_units         <= cfg_data;
        kcms_pkg::REG_DASH: dash_units        <= cfg_data;
        kcms_pkg::REG_EGAP: element_gap_units <= cfg_data;
        kcms_pkg::REG_CGAP: char_gap_units    <= cfg_data;
        default: begin
          dot_units <= dot_units;
        end
      endcase
    end
  end

  assign cfg_len.dot  = kcms_pkg::len_of(dot_units);
  assign cfg_len.dash = kcms_pkg::len_of(dash_units);
  assign cfg_len.egap = kcms_pkg::len_of(element_gap_units);
  assign cfg_len.cgap = kcms_pkg::len_of(char_gap_units);

  kcms_front #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_front (
    .key_valid (key_valid),
    .key_ready (key_ready),
    .key_item  (key_item),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  kcms_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wdata     (push_data),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .rdata     (q_data)
  );

  kcms_back #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_len    (cfg_len),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .pop        (pop),
    .elem_valid (elem_valid),
    .elem_ready (elem_ready),
    .elem_item  (elem_item)
  );

`ifndef NO_ASSERTIONS
  // a taken tone is always followed at once by its element gap
  a_tone_then_gap: assert property (@(posedge clk) disable iff (rst)
    (elem_valid && elem_ready && elem_item.tone_on) |=>
      (elem_valid && elem_item.element_kind == kcms_pkg::KIND_ELEM_GAP))
    else $error("tone not followed by element gap");

  // an accepted key leaves work waiting in the queue
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    (key_valid && key_ready) |=> q_valid)
    else $error("accepted key missing from queue");

  a_gap_len: assert property (@(posedge clk) disable iff (rst)
    (elem_valid && elem_item.element_kind == kcms_pkg::KIND_ELEM_GAP) |->
      (elem_item.length_units == cfg_len.egap))
    else $error("element gap length does not match register");

  a_last_char: assert property (@(posedge clk) disable iff (rst)
    (elem_valid && elem_item.last) |->
      (elem_item.element_kind == kcms_pkg::KIND_CHAR_GAP &&
       elem_item.length_units == cfg_len.cgap))
    else $error("last set on wrong element");
`endif

endmodule

`default_nettype wire
